@@ hdl/masked_histogram_entropy_score_assert.svh @@
// Assertion macros for the masked histogram entropy score block.
// Used by the port checker; needs clock and reset in the enclosing scope.
`ifndef MASKED_HISTOGRAM_ENTROPY_SCORE_ASSERT_SVH
`define MASKED_HISTOGRAM_ENTROPY_SCORE_ASSERT_SVH

// checked only outside reset
`define MHES_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("mhes assertion failed");

// checked through reset as well
`define MHES_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("mhes reset assertion failed");

`endif

@@ hdl/mhes_pkg.sv @@
// Shared constants, types and the score function of the histogram entropy block.
// No dependencies.
package mhes_pkg;

   localparam int COUNT_BITS  = 21;
   localparam int FRAC_BITS   = 16;
   localparam int LUMA_BITS   = 8;
   localparam int NUM_BINS    = 1 << LUMA_BITS;
   localparam int SUM_BITS    = COUNT_BITS + LUMA_BITS;
   localparam int MANT_BITS   = 31;
   localparam int NORM_BITS   = (SUM_BITS > MANT_BITS) ? SUM_BITS : MANT_BITS;
   localparam int EXP_BITS    = $clog2(NORM_BITS);
   localparam int LOG_BITS    = EXP_BITS + FRAC_BITS;
   localparam int ITER_BITS   = $clog2(FRAC_BITS);
   localparam int PROD_BITS   = COUNT_BITS + LOG_BITS;
   localparam int ACC_BITS    = PROD_BITS + LUMA_BITS;
   localparam int DIV_BITS    = ACC_BITS + 1;
   localparam int DSTEP_BITS  = $clog2(DIV_BITS);
   localparam int H_BITS      = FRAC_BITS + 4;
   localparam int SW_BITS     = H_BITS + 5;
   localparam int ENT_BITS    = 20;
   localparam int SCORE_BITS  = 7;
   localparam int SCORE_MAX   = 100;
   localparam int SCORE_MUL   = 25;
   localparam int Q_DEPTH     = 4;
   localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);

   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [H_BITS-1:0]     H_MAX   = {4'd8, {FRAC_BITS{1'b0}}};

   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      logic [LUMA_BITS-1:0] luma;
      logic                 in_mask;
      logic                 frame_end;
   } req_type;

   typedef struct packed {
      logic [ENT_BITS-1:0]   entropy_q16;
      logic [SCORE_BITS-1:0] score;
      logic                  empty_region;
   } rsp_type;

   typedef struct packed {
      logic clearing;
   } stat_type;

   // round(12.5 * h), half up, clamped
   function automatic logic [SCORE_BITS-1:0] score_of(logic [H_BITS-1:0] h);
      logic [SW_BITS-1:0] t;
      t = ({5'b0, h} * SW_BITS'(SCORE_MUL)) + (SW_BITS'(1) << FRAC_BITS);
      t = t >> (FRAC_BITS + 1);
      if (t > SW_BITS'(SCORE_MAX)) begin
         return SCORE_BITS'(SCORE_MAX);
      end
      return SCORE_BITS'(t);
   endfunction

endpackage

@@ hdl/mhes_front.sv @@
// Input stage: takes pixel transactions, drops those with no effect, feeds the queue.
// Depends on mhes_pkg.
module mhes_front import mhes_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   input  stat_type stat,
   output logic     push_valid,
   output req_type  push_item,
   input  logic     q_full
);

   logic    f_valid_ff, f_valid_in;
   req_type f_item_ff, f_item_in;
   logic    accept;

   assign req_stall  = stat.clearing || (f_valid_ff && q_full);
   assign accept     = req_valid && !req_stall;
   assign push_valid = f_valid_ff;
   assign push_item  = f_item_ff;

   always_comb begin
      f_valid_in = f_valid_ff && q_full;
      f_item_in  = f_item_ff;
      if (accept) begin
         // unmasked pixels that do not end a frame change nothing
         f_valid_in = req_data.in_mask || req_data.frame_end;
         f_item_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
      f_item_ff <= f_item_in;
   end

endmodule

@@ hdl/mhes_queue.sv @@
// Small FIFO between the input stage and the histogram/entropy engine.
// Depends on mhes_pkg.
module mhes_queue import mhes_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  req_type push_item,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output req_type head
);

   req_type               entry_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_PTR_BITS:0]   count_ff;
   logic                  push_ok, pop_ok;

   assign full       = (count_ff == (Q_PTR_BITS+1)'(Q_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign push_ok    = push_valid && !full;
   assign pop_ok     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push_ok && !pop_ok) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop_ok && !push_ok) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hdl/mhes_log2.sv @@
// Iterative fixed-point log2: one-bit normalize, then one squaring per fraction bit.
// Depends on mhes_pkg.
module mhes_log2 import mhes_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SUM_BITS-1:0] x,
   output logic                done,
   output logic [LOG_BITS-1:0] result
);

   localparam logic [1:0] L_IDLE = 2'd0;
   localparam logic [1:0] L_NORM = 2'd1;
   localparam logic [1:0] L_SQR  = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [NORM_BITS-1:0]   norm_ff, norm_in;
   logic [EXP_BITS-1:0]    exp_ff, exp_in;
   logic [MANT_BITS-1:0]   mant_ff, mant_in;
   logic [LOG_BITS-1:0]    res_ff, res_in;
   logic [ITER_BITS-1:0]   iter_ff, iter_in;
   logic                   done_ff, done_in;
   logic [2*MANT_BITS-1:0] sq;

   assign sq     = {{MANT_BITS{1'b0}}, mant_ff} * {{MANT_BITS{1'b0}}, mant_ff};
   assign done   = done_ff;
   assign result = res_ff;

   always_comb begin
      state_in = state_ff;
      norm_in  = norm_ff;
      exp_in   = exp_ff;
      mant_in  = mant_ff;
      res_in   = res_ff;
      iter_in  = iter_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         L_IDLE: begin
            if (start) begin
               norm_in  = NORM_BITS'(x);
               exp_in   = EXP_BITS'(NORM_BITS - 1);
               state_in = L_NORM;
            end
         end
         L_NORM: begin
            if (norm_ff[NORM_BITS-1]) begin
               mant_in  = norm_ff[NORM_BITS-1 -: MANT_BITS];
               res_in   = LOG_BITS'(exp_ff);
               iter_in  = '0;
               state_in = L_SQR;
            end else begin
               norm_in = norm_ff << 1;
               exp_in  = exp_ff - 1'b1;
            end
         end
         L_SQR: begin
            // mantissa squared; at or above 2.0 gives a one bit and halves
            if (sq[2*MANT_BITS-1]) begin
               mant_in = sq[2*MANT_BITS-1 -: MANT_BITS];
               res_in  = {res_ff[LOG_BITS-2:0], 1'b1};
            end else begin
               mant_in = sq[2*MANT_BITS-2 -: MANT_BITS];
               res_in  = {res_ff[LOG_BITS-2:0], 1'b0};
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_BITS'(FRAC_BITS - 1)) begin
               done_in  = 1'b1;
               state_in = L_IDLE;
            end
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      norm_ff <= norm_in;
      exp_ff  <= exp_in;
      mant_ff <= mant_in;
      res_ff  <= res_in;
      iter_ff <= iter_in;
   end

endmodule

@@ hdl/mhes_back.sv @@
// Histogram memory with forwarded read-modify-write, per-frame entropy sweep,
// divider and result register. Depends on mhes_pkg and mhes_log2.
module mhes_back import mhes_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   input  req_type  q_item,
   output logic     q_pop,
   output stat_type stat,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam logic [3:0] B_CLR  = 4'd0;
   localparam logic [3:0] B_HIST = 4'd1;
   localparam logic [3:0] B_RD   = 4'd2;
   localparam logic [3:0] B_CHK  = 4'd3;
   localparam logic [3:0] B_LOG  = 4'd4;
   localparam logic [3:0] B_ACC  = 4'd5;
   localparam logic [3:0] B_LOGN = 4'd6;
   localparam logic [3:0] B_DIV  = 4'd7;
   localparam logic [3:0] B_HVAL = 4'd8;
   localparam logic [3:0] B_OUT  = 4'd9;

   count_type hist_mem [NUM_BINS];

   logic [3:0]           state_ff, state_in;
   logic [LUMA_BITS-1:0] idx_ff, idx_in;
   logic                 p1_valid_ff, p1_valid_in;
   req_type              p1_item_ff, p1_item_in;
   count_type            rdata_ff;
   logic                 wr_valid_ff, wr_valid_in;
   logic [LUMA_BITS-1:0] wr_addr_ff, wr_addr_in;
   count_type            wr_data_ff, wr_data_in;
   count_type            tot_ff, tot_in;
   logic [SUM_BITS-1:0]  n_ff, n_in;
   logic [ACC_BITS-1:0]  s_ff, s_in;
   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic [LOG_BITS-1:0]  l_ff, l_in;
   logic [SUM_BITS-1:0]  rem_ff, rem_in;
   logic [DIV_BITS-1:0]  quo_ff, quo_in;
   logic [DSTEP_BITS-1:0] step_ff, step_in;
   logic                 empty_ff, empty_in;
   logic [H_BITS-1:0]    h_ff, h_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 mem_re, mem_we;
   logic [LUMA_BITS-1:0] mem_raddr, mem_waddr;
   count_type            mem_wdata;
   count_type            cur, bump;
   logic                 adv;
   logic                 log_start, log_done;
   logic [SUM_BITS-1:0]  log_x;
   logic [LOG_BITS-1:0]  log_res;
   logic [SUM_BITS:0]    trial;
   logic [DIV_BITS-1:0]  lq, diff;

   mhes_log2 u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .x      (log_x),
      .done   (log_done),
      .result (log_res)
   );

   // previous cycle's write is not yet visible in the read data
   assign cur  = (wr_valid_ff && wr_addr_ff == p1_item_ff.luma) ? wr_data_ff : rdata_ff;
   assign bump = (cur == CNT_MAX) ? cur : count_type'(cur + 1'b1);

   assign trial = {rem_ff, quo_ff[DIV_BITS-1]};
   assign lq    = DIV_BITS'(l_ff);
   assign diff  = lq - quo_ff;

   assign stat.clearing = (state_ff == B_CLR);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      p1_valid_in  = 1'b0;
      p1_item_in   = p1_item_ff;
      wr_valid_in  = 1'b0;
      wr_addr_in   = wr_addr_ff;
      wr_data_in   = wr_data_ff;
      tot_in       = tot_ff;
      n_in         = n_ff;
      s_in         = s_ff;
      prod_in      = prod_ff;
      l_in         = l_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      empty_in     = empty_ff;
      h_in         = h_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_re       = 1'b0;
      mem_raddr    = q_item.luma;
      mem_we       = 1'b0;
      mem_waddr    = p1_item_ff.luma;
      mem_wdata    = bump;
      q_pop        = 1'b0;
      adv          = 1'b0;
      log_start    = 1'b0;
      log_x        = '0;

      unique case (state_ff)
         B_CLR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = '0;
            idx_in    = idx_ff + 1'b1;
            if (&idx_ff) begin
               state_in = B_HIST;
            end
         end
         B_HIST: begin
            q_pop       = q_valid && !(p1_valid_ff && p1_item_ff.frame_end);
            mem_re      = q_pop;
            p1_valid_in = q_pop;
            if (q_pop) begin
               p1_item_in = q_item;
            end
            if (p1_valid_ff && p1_item_ff.in_mask) begin
               mem_we      = 1'b1;
               wr_valid_in = 1'b1;
               wr_addr_in  = p1_item_ff.luma;
               wr_data_in  = bump;
               tot_in      = (tot_ff == CNT_MAX) ? tot_ff : count_type'(tot_ff + 1'b1);
            end
            if (p1_valid_ff && p1_item_ff.frame_end) begin
               idx_in   = '0;
               n_in     = '0;
               s_in     = '0;
               state_in = B_RD;
            end
         end
         B_RD: begin
            // read the bin and clear it in the same cycle
            mem_re    = 1'b1;
            mem_raddr = idx_ff;
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = '0;
            state_in  = B_CHK;
         end
         B_CHK: begin
            n_in = n_ff + SUM_BITS'(rdata_ff);
            if (rdata_ff != '0) begin
               log_start = 1'b1;
               log_x     = SUM_BITS'(rdata_ff);
               state_in  = B_LOG;
            end else begin
               adv = 1'b1;
            end
         end
         B_LOG: begin
            if (log_done) begin
               prod_in  = {{LOG_BITS{1'b0}}, rdata_ff} * {{COUNT_BITS{1'b0}}, log_res};
               state_in = B_ACC;
            end
         end
         B_ACC: begin
            s_in = s_ff + ACC_BITS'(prod_ff);
            adv  = 1'b1;
         end
         B_LOGN: begin
            if (log_done) begin
               l_in     = log_res;
               rem_in   = '0;
               quo_in   = DIV_BITS'(s_ff) + DIV_BITS'(n_ff >> 1);
               step_in  = '0;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            // restoring division, one quotient bit per cycle
            if (trial >= {1'b0, n_ff}) begin
               rem_in = SUM_BITS'(trial - {1'b0, n_ff});
               quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
            end else begin
               rem_in = trial[SUM_BITS-1:0];
               quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == DSTEP_BITS'(DIV_BITS - 1)) begin
               state_in = B_HVAL;
            end
         end
         B_HVAL: begin
            h_in = '0;
            if (!empty_ff && lq > quo_ff) begin
               h_in = (diff > DIV_BITS'(H_MAX)) ? H_MAX : H_BITS'(diff);
            end
            state_in = B_OUT;
         end
         B_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.entropy_q16  = ENT_BITS'(h_ff);
               rsp_data_in.score        = score_of(h_ff);
               rsp_data_in.empty_region = empty_ff;
               tot_in                   = '0;
               state_in                 = B_HIST;
            end
         end
         default: begin
            state_in = B_CLR;
            idx_in   = '0;
         end
      endcase

      if (adv) begin
         if (&idx_ff) begin
            empty_in = (tot_ff == '0);
            if (tot_ff == '0) begin
               state_in = B_HVAL;
            end else begin
               log_start = 1'b1;
               log_x     = n_ff;
               state_in  = B_LOGN;
            end
         end else begin
            idx_in   = idx_ff + 1'b1;
            state_in = B_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= hist_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLR;
         idx_ff       <= '0;
         p1_valid_ff  <= 1'b0;
         wr_valid_ff  <= 1'b0;
         tot_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         p1_valid_ff  <= p1_valid_in;
         wr_valid_ff  <= wr_valid_in;
         tot_ff       <= tot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p1_item_ff  <= p1_item_in;
      wr_addr_ff  <= wr_addr_in;
      wr_data_ff  <= wr_data_in;
      n_ff        <= n_in;
      s_ff        <= s_in;
      prod_ff     <= prod_in;
      l_ff        <= l_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      empty_ff    <= empty_in;
      h_ff        <= h_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ hdl/masked_histogram_entropy_score.sv @@
// Pixels: one transaction per cycle while req_stall is low; the histogram
// read-modify-write is forwarded. Frame end: the 256 bins are swept and cleared
// in turn; each occupied bin goes through the shared log2 unit; unless the region
// is empty, the total does too and the divider runs; then the result is formed.
// Reset: synchronous; a clearing pass follows, req_stall high during it.
module masked_histogram_entropy_score import mhes_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   stat_type stat;
   logic     push_valid, q_full, q_pop, q_valid;
   req_type  push_item, q_item;

   mhes_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .stat       (stat),
      .push_valid (push_valid),
      .push_item  (push_item),
      .q_full     (q_full)
   );

   mhes_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head       (q_item)
   );

   mhes_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hdl/mhes_checker.sv @@
// Port-level checks for the entropy score block, bound to the top level.
// Depends on mhes_pkg and masked_histogram_entropy_score_assert.svh.
`include "masked_histogram_entropy_score_assert.svh"

module mhes_checker import mhes_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // clearing pass holds off input, no result pending
   `MHES_ASSERT_RST(a_reset_quiet, reset |=> !rsp_valid && req_stall)

   `MHES_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))

   `MHES_ASSERT(a_empty_zero, rsp_valid && rsp_data.empty_region |-> rsp_data.entropy_q16 == '0)

   `MHES_ASSERT(a_ent_max, rsp_valid |-> rsp_data.entropy_q16 <= ENT_BITS'(H_MAX))

   `MHES_ASSERT(a_score, rsp_valid |-> rsp_data.score == score_of(H_BITS'(rsp_data.entropy_q16)))

endmodule

bind masked_histogram_entropy_score mhes_checker u_mhes_checker (.*);
